@@ rtl/tile_dirty_detector_defines.svh @@
// Assertion macros used by the checker file of the tile dirty detector.
`ifndef TILE_DIRTY_DETECTOR_DEFINES_SVH
`define TILE_DIRTY_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TDD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TDD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tdd_pkg.sv @@
package tdd_pkg;

  localparam int TILE_SIZE  = 64;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W   = 32;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int WDIM_W  = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W  = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W  = $clog2(DEPTH);

  localparam int BAND_TILES = (MAX_WIDTH + TILE_SIZE - 1) / TILE_SIZE;
  localparam int COL_TILES  = BAND_TILES;
  localparam int ROW_TILES  = (MAX_HEIGHT + TILE_SIZE - 1) / TILE_SIZE;
  localparam int TCOL_W     = $clog2(BAND_TILES);
  localparam int TROW_W     = $clog2(ROW_TILES);
  localparam int TX_W       = $clog2(COL_TILES + 1);
  localparam int TY_W       = $clog2(ROW_TILES + 1);

  // Fixed widths of the result fields and configuration registers.
  localparam int TILE_IDX_W = 4;
  localparam int TOTAL_W    = 9;
  localparam int KIND_W     = 2;
  localparam int CFG_DIM_W  = 11;
  localparam int PCT_W      = 7;
  localparam int PROD_W     = TOTAL_W + PCT_W;
  localparam int PERCENT_SCALE = 100;

  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 4;
  localparam int REG_IDX_W  = PADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD    = 2'd2;

  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PATCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FULL  = 2'd2;

  typedef struct packed {
    logic [WDIM_W-1:0]  width;
    logic [HDIM_W-1:0]  height;
    logic [TOTAL_W-1:0] total;
    logic [PCT_W-1:0]   pct;
  } geom_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pixel;
    logic [TCOL_W-1:0] tcol;
    logic [TROW_W-1:0] trow;
    logic              tile_end;
    logic              frame_end;
    logic              pvalid;
  } item_t;

endpackage

@@ rtl/tile_dirty_detector.sv @@
// Tile dirty detector.
// Pixels enter in raster order on the input channel (in_valid, in_stall,
// pixel). Each pixel is compared with the same position of the stored
// previous frame and then written there. One result per 64x64 tile leaves
// on the output channel (out_valid, out_stall and the tile fields) at the
// tile's bottom-right pixel; the frame's last tile also carries frame_done
// and the frame decision in frame_kind.
// Frame size and threshold are set over the APB port; a size write
// restarts the frame and makes the next one a first (full) frame.
// Throughput is one pixel per cycle while in_stall is low. The pixel that
// completes a tile passes the frame store read, then the compare and tile
// bookkeeping into the output register, before its result appears.
// When out_stall holds a result, pixels that complete no tile still flow;
// the next tile-completing pixel waits in the compare stage and in_stall
// rises until the output register drains.
// Reset clears position, tile flags, dirty count and the stored-frame
// valid flag; the frame store itself needs no clearing.
module tile_dirty_detector
  import tdd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIX_W-1:0]      pixel,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [TILE_IDX_W-1:0] tile_column,
  output logic [TILE_IDX_W-1:0] tile_row,
  output logic                  tile_changed,
  output logic                  frame_done,
  output logic [KIND_W-1:0]     frame_kind,
  output logic [TOTAL_W-1:0]    dirty_tile_count,
  output logic [TOTAL_W-1:0]    total_tile_count
);

  geom_t             geom;
  logic              restart;
  logic              s1_fire;
  logic              s1_valid;
  item_t             s1_item;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [PIX_W-1:0]  prev_pixel;

  assign pready = 1'b1;

  tdd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .restart (restart),
    .geom    (geom)
  );

  tdd_raster u_raster (
    .clk      (clk),
    .rst      (rst),
    .restart  (restart),
    .geom     (geom),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .pixel    (pixel),
    .s1_fire  (s1_fire),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  tdd_frame_store u_store (
    .clk      (clk),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .wr_en    (s1_fire),
    .wr_addr  (s1_item.addr),
    .wr_data  (s1_item.pixel),
    .rd_pixel (prev_pixel)
  );

  tdd_tile_track u_track (
    .clk              (clk),
    .rst              (rst),
    .restart          (restart),
    .geom             (geom),
    .s1_valid         (s1_valid),
    .s1_item          (s1_item),
    .prev_pixel       (prev_pixel),
    .s1_fire          (s1_fire),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .tile_column      (tile_column),
    .tile_row         (tile_row),
    .tile_changed     (tile_changed),
    .frame_done       (frame_done),
    .frame_kind       (frame_kind),
    .dirty_tile_count (dirty_tile_count),
    .total_tile_count (total_tile_count)
  );

endmodule

@@ rtl/tdd_regs.sv @@
module tdd_regs
  import tdd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  restart,
  output geom_t                 geom
);

  logic [CFG_DIM_W-1:0] frame_width;
  logic [CFG_DIM_W-1:0] frame_height;
  logic [PCT_W-1:0]     full_threshold_percent;

  logic                 wr;
  logic [REG_IDX_W-1:0] idx;
  logic [WDIM_W-1:0]    w;
  logic [HDIM_W-1:0]    h;
  logic [WDIM_W:0]      tx_sum;
  logic [HDIM_W:0]      ty_sum;
  logic [TX_W-1:0]      tiles_x;
  logic [TY_W-1:0]      tiles_y;

  assign wr  = psel && penable && pwrite;
  assign idx = paddr[PADDR_W-1:2];
  assign restart = wr && (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width            <= CFG_DIM_W'(640);
      frame_height           <= CFG_DIM_W'(480);
      full_threshold_percent <= PCT_W'(55);
    end else if (wr) begin
      unique case (idx)
        REG_FRAME_WIDTH:  frame_width            <= pwdata[CFG_DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height           <= pwdata[CFG_DIM_W-1:0];
        REG_THRESHOLD:    full_threshold_percent <= pwdata[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height);
      REG_THRESHOLD:    prdata = APB_DATA_W'(full_threshold_percent);
      default:          prdata = '0;
    endcase
  end

  // A size of zero acts as one; sizes above the maximum act as the maximum.
  always_comb begin
    if (frame_width == '0) begin
      w = WDIM_W'(1);
    end else if (int'(frame_width) > MAX_WIDTH) begin
      w = WDIM_W'(MAX_WIDTH);
    end else begin
      w = WDIM_W'(frame_width);
    end
    if (frame_height == '0) begin
      h = HDIM_W'(1);
    end else if (int'(frame_height) > MAX_HEIGHT) begin
      h = HDIM_W'(MAX_HEIGHT);
    end else begin
      h = HDIM_W'(frame_height);
    end
  end

  assign tx_sum  = {1'b0, w} + (WDIM_W + 1)'(TILE_SIZE - 1);
  assign ty_sum  = {1'b0, h} + (HDIM_W + 1)'(TILE_SIZE - 1);
  assign tiles_x = TX_W'(tx_sum / TILE_SIZE);
  assign tiles_y = TY_W'(ty_sum / TILE_SIZE);

  // Both factors are widened first so a full 16 by 16 grid gives 256.
  assign geom.width  = w;
  assign geom.height = h;
  assign geom.total  = TOTAL_W'(tiles_x) * TOTAL_W'(tiles_y);
  assign geom.pct    = full_threshold_percent;

endmodule

@@ rtl/tdd_raster.sv @@
module tdd_raster
  import tdd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              restart,
  input  geom_t             geom,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [PIX_W-1:0]  pixel,
  input  logic              s1_fire,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr,
  output logic              s1_valid,
  output item_t             s1_item
);

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             pvalid;

  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row_next;
  logic [COL_W-1:0] wm1;
  logic [ROW_W-1:0] hm1;
  logic [COL_W-1:0] colc;
  logic [ROW_W-1:0] rowc;
  logic             accept;
  logic             last_col;
  logic             last_row;
  logic             frame_end;
  item_t            item;

  assign in_stall = rst || (s1_valid && !s1_fire);
  assign accept   = in_valid && !in_stall;
  assign rd_en    = accept;

  assign wm1  = COL_W'(geom.width - 1'b1);
  assign hm1  = ROW_W'(geom.height - 1'b1);
  assign colc = (col > wm1) ? wm1 : col;
  assign rowc = (row > hm1) ? hm1 : row;

  assign last_col  = (colc % TILE_SIZE == COL_W'(TILE_SIZE - 1)) || (colc == wm1);
  assign last_row  = (rowc % TILE_SIZE == ROW_W'(TILE_SIZE - 1)) || (rowc == hm1);
  assign frame_end = (colc == wm1) && (rowc == hm1);

  assign rd_addr = ADDR_W'(rowc) * ADDR_W'(MAX_WIDTH) + ADDR_W'(colc);

  always_comb begin
    if (colc == wm1) begin
      col_next = '0;
      row_next = (rowc == hm1) ? '0 : rowc + 1'b1;
    end else begin
      col_next = colc + 1'b1;
      row_next = rowc;
    end
  end

  always_comb begin
    item.addr      = rd_addr;
    item.pixel     = pixel;
    item.tcol      = TCOL_W'(colc / TILE_SIZE);
    item.trow      = TROW_W'(rowc / TILE_SIZE);
    item.tile_end  = last_col && last_row;
    item.frame_end = frame_end;
    item.pvalid    = pvalid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      pvalid   <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      if (restart) begin
        col    <= '0;
        row    <= '0;
        pvalid <= 1'b0;
      end else if (accept) begin
        col <= col_next;
        row <= row_next;
        if (frame_end) begin
          pvalid <= 1'b1;
        end
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item;
    end
  end

endmodule

@@ rtl/tdd_frame_store.sv @@
module tdd_frame_store
  import tdd_pkg::*;
(
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [PIX_W-1:0]  wr_data,
  output logic [PIX_W-1:0]  rd_pixel
);

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_q;
  logic [PIX_W-1:0] fwd_data;
  logic             fwd_hit;

  // A read in the same cycle as a write to the same position returns the
  // new pixel; this only happens for a one-pixel frame.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      fwd_hit  <= wr_en && (wr_addr == rd_addr);
      fwd_data <= wr_data;
    end
  end

  assign rd_pixel = fwd_hit ? fwd_data : rd_q;

endmodule

@@ rtl/tdd_tile_track.sv @@
module tdd_tile_track
  import tdd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  restart,
  input  geom_t                 geom,
  input  logic                  s1_valid,
  input  item_t                 s1_item,
  input  logic [PIX_W-1:0]      prev_pixel,
  output logic                  s1_fire,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [TILE_IDX_W-1:0] tile_column,
  output logic [TILE_IDX_W-1:0] tile_row,
  output logic                  tile_changed,
  output logic                  frame_done,
  output logic [KIND_W-1:0]     frame_kind,
  output logic [TOTAL_W-1:0]    dirty_tile_count,
  output logic [TOTAL_W-1:0]    total_tile_count
);

  logic [BAND_TILES-1:0] flags;
  logic [TOTAL_W-1:0]    dirty;

  logic                  px_changed;
  logic                  tile_chg;
  logic                  emit;
  logic [TOTAL_W-1:0]    dirty_new;
  logic [PROD_W-1:0]     lhs;
  logic [PROD_W-1:0]     rhs;
  logic [KIND_W-1:0]     kind;

  assign px_changed = !s1_item.pvalid || (prev_pixel != s1_item.pixel);
  assign s1_fire    = s1_valid && !(s1_item.tile_end && out_valid && out_stall);
  assign emit       = s1_fire && s1_item.tile_end;
  assign tile_chg   = flags[s1_item.tcol] || px_changed;

  assign dirty_new = (tile_chg && dirty < geom.total) ? dirty + 1'b1 : dirty;
  assign lhs = PROD_W'(dirty_new) * PROD_W'(PERCENT_SCALE);
  assign rhs = PROD_W'(geom.total) * PROD_W'(geom.pct);

  always_comb begin
    if (!s1_item.frame_end) begin
      kind = KIND_NONE;
    end else if (!s1_item.pvalid) begin
      kind = KIND_FULL;
    end else if (dirty_new == '0) begin
      kind = KIND_NONE;
    end else if (lhs > rhs) begin
      kind = KIND_FULL;
    end else begin
      kind = KIND_PATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags     <= '0;
      dirty     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (restart) begin
        flags <= '0;
        dirty <= '0;
      end else if (s1_fire) begin
        if (s1_item.tile_end) begin
          if (s1_item.frame_end) begin
            flags <= '0;
            dirty <= '0;
          end else begin
            flags[s1_item.tcol] <= 1'b0;
            dirty               <= dirty_new;
          end
        end else if (px_changed) begin
          flags[s1_item.tcol] <= 1'b1;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      tile_column      <= TILE_IDX_W'(s1_item.tcol);
      tile_row         <= TILE_IDX_W'(s1_item.trow);
      tile_changed     <= tile_chg;
      frame_done       <= s1_item.frame_end;
      frame_kind       <= kind;
      dirty_tile_count <= dirty_new;
      total_tile_count <= geom.total;
    end
  end

endmodule

@@ rtl/tdd_checker.sv @@
`include "tile_dirty_detector_defines.svh"

module tdd_checker
  import tdd_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [TILE_IDX_W-1:0] tile_column,
  input logic [TILE_IDX_W-1:0] tile_row,
  input logic                  tile_changed,
  input logic                  frame_done,
  input logic [KIND_W-1:0]     frame_kind,
  input logic [TOTAL_W-1:0]    dirty_tile_count,
  input logic [TOTAL_W-1:0]    total_tile_count
);

  // The decision is only given on the frame's last tile.
  `TDD_ASSERT_IMP(a_kind_only_at_end, clk, rst, out_valid && !frame_done, frame_kind == KIND_NONE, "frame_kind set before frame end")

  // The dirty count saturates at the tile total.
  `TDD_ASSERT_IMP(a_dirty_bounded, clk, rst, out_valid, dirty_tile_count <= total_tile_count, "dirty count above tile total")

  // A frame with no change must have counted no dirty tile, and its last
  // tile must not be reported changed.
  `TDD_ASSERT_IMP(a_none_means_clean, clk, rst, out_valid && frame_done && frame_kind == KIND_NONE, dirty_tile_count == '0 && !tile_changed, "no-change frame with dirty tiles")

  // A held result keeps its contents.
  `TDD_ASSERT_NXT(a_hold_result, clk, rst, out_valid && out_stall, out_valid && $stable(dirty_tile_count) && $stable(frame_kind) && $stable(tile_column) && $stable(tile_row), "held result changed")

endmodule

bind tile_dirty_detector tdd_checker u_tdd_checker (.*);

@@ dv/tb_tile_dirty_detector.sv @@
module tb_tile_dirty_detector;
  import tdd_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PIXELS = 250;
  localparam int RANDOM_TILES  = 12;
  localparam int PRINT_LIMIT   = 100;

  typedef struct {
    logic [TILE_IDX_W-1:0] tcol;
    logic [TILE_IDX_W-1:0] trow;
    logic                  changed;
    logic                  done;
    logic [KIND_W-1:0]     kind;
    logic [TOTAL_W-1:0]    dirty;
    logic [TOTAL_W-1:0]    total;
  } tile_report_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_W-1:0]    paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PIX_W-1:0]      pixel = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [TILE_IDX_W-1:0] tile_column;
  logic [TILE_IDX_W-1:0] tile_row;
  logic                  tile_changed;
  logic                  frame_done;
  logic [KIND_W-1:0]     frame_kind;
  logic [TOTAL_W-1:0]    dirty_tile_count;
  logic [TOTAL_W-1:0]    total_tile_count;

  // Mirror of the block: registers, stored frame and tile bookkeeping.
  logic [CFG_DIM_W-1:0] cfg_width = 11'd640;
  logic [CFG_DIM_W-1:0] cfg_height = 11'd480;
  logic [PCT_W-1:0]     cfg_pct = 7'd55;
  bit                   stored_ok = 1'b0;
  int unsigned          pos_col = 0;
  int unsigned          pos_row = 0;
  int unsigned          dirty_so_far = 0;
  bit                   band_flags [BAND_TILES];
  logic [PIX_W-1:0]     prev_pixels [int unsigned];
  tile_report_t         expected_tiles [$];

  logic [PIX_W-1:0] picture [$];
  tile_report_t     next_tile;
  bit               steady = 1'b0;
  int unsigned      pixels_sent = 0;
  int unsigned      tiles_seen = 0;
  int unsigned      mismatches = 0;
  int unsigned      cycle_count = 0;

  tile_dirty_detector u_dut (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .pixel            (pixel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .tile_column      (tile_column),
    .tile_row         (tile_row),
    .tile_changed     (tile_changed),
    .frame_done       (frame_done),
    .frame_kind       (frame_kind),
    .dirty_tile_count (dirty_tile_count),
    .total_tile_count (total_tile_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int draw_wait();
    return steady ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic int unsigned clamp_dim(logic [CFG_DIM_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  function automatic void restart_frame_state();
    pos_col = 0;
    pos_row = 0;
    dirty_so_far = 0;
    foreach (band_flags[i]) band_flags[i] = 1'b0;
  endfunction

  // Compares one pixel with the stored frame and queues the tile report
  // when the pixel closes a tile.
  function automatic void track_pixel(logic [PIX_W-1:0] px);
    int unsigned w, h, c, r, tc, tr, total, addr;
    bit last_c, last_r, at_end, chg;
    tile_report_t rep;
    w = clamp_dim(cfg_width, MAX_WIDTH);
    h = clamp_dim(cfg_height, MAX_HEIGHT);
    c = (pos_col >= w) ? w - 1 : pos_col;
    r = (pos_row >= h) ? h - 1 : pos_row;
    tc = c / TILE_SIZE;
    tr = r / TILE_SIZE;
    total = ((w + TILE_SIZE - 1) / TILE_SIZE) * ((h + TILE_SIZE - 1) / TILE_SIZE);
    addr = r * MAX_WIDTH + c;
    if (!stored_ok || prev_pixels[addr] !== px) band_flags[tc % BAND_TILES] = 1'b1;
    prev_pixels[addr] = px;
    last_c = (c % TILE_SIZE == TILE_SIZE - 1) || (c == w - 1);
    last_r = (r % TILE_SIZE == TILE_SIZE - 1) || (r == h - 1);
    at_end = (c == w - 1) && (r == h - 1);
    if (c + 1 >= w) begin
      pos_col = 0;
      pos_row = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      pos_col = c + 1;
      pos_row = r;
    end
    if (!(last_c && last_r)) return;
    chg = band_flags[tc % BAND_TILES];
    band_flags[tc % BAND_TILES] = 1'b0;
    if (chg && dirty_so_far < total) dirty_so_far++;
    rep.kind = KIND_NONE;
    if (at_end) begin
      if (!stored_ok) rep.kind = KIND_FULL;
      else if (dirty_so_far == 0) rep.kind = KIND_NONE;
      else if (dirty_so_far * PERCENT_SCALE > total * cfg_pct) rep.kind = KIND_FULL;
      else rep.kind = KIND_PATCH;
    end
    rep.tcol = tc[TILE_IDX_W-1:0];
    rep.trow = tr[TILE_IDX_W-1:0];
    rep.changed = chg;
    rep.done = at_end;
    rep.dirty = dirty_so_far[TOTAL_W-1:0];
    rep.total = total[TOTAL_W-1:0];
    expected_tiles.insert(expected_tiles.size(), rep);
    if (at_end) begin
      stored_ok = 1'b1;
      restart_frame_state();
    end
  endfunction

  task automatic log_mismatch(string msg);
    if (mismatches < PRINT_LIMIT) $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) log_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      tiles_seen++;
      if (expected_tiles.size() == 0) begin
        log_mismatch($sformatf("tile (%0d,%0d) reported with nothing pending",
                               tile_column, tile_row));
      end else begin
        next_tile = expected_tiles.pop_front();
        check_field("tile_column", 32'(tile_column), 32'(next_tile.tcol));
        check_field("tile_row", 32'(tile_row), 32'(next_tile.trow));
        check_field("tile_changed", 32'(tile_changed), 32'(next_tile.changed));
        check_field("frame_done", 32'(frame_done), 32'(next_tile.done));
        check_field("frame_kind", 32'(frame_kind), 32'(next_tile.kind));
        check_field("dirty_tile_count", 32'(dirty_tile_count), 32'(next_tile.dirty));
        check_field("total_tile_count", 32'(total_tile_count), 32'(next_tile.total));
      end
    end
  end

  // Result side: a fresh stall length is drawn for every item taken.
  initial begin : result_sink
    int n;
    wait (!rst);
    forever begin
      n = draw_wait();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_pixel(logic [PIX_W-1:0] px);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel <= px;
    do @(posedge clk); while (in_stall);
    track_pixel(px);
    pixels_sent++;
  endtask

  // Holds the pixel stream until every pending tile report has come out and
  // the pipeline has had time to empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_tiles.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, int unsigned value);
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH: begin
        cfg_width = value[CFG_DIM_W-1:0];
        stored_ok = 1'b0;
        restart_frame_state();
      end
      REG_FRAME_HEIGHT: begin
        cfg_height = value[CFG_DIM_W-1:0];
        stored_ok = 1'b0;
        restart_frame_state();
      end
      REG_THRESHOLD: cfg_pct = value[PCT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_size(int unsigned w, int unsigned h);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    picture.delete();
    repeat (clamp_dim(CFG_DIM_W'(w), MAX_WIDTH) * clamp_dim(CFG_DIM_W'(h), MAX_HEIGHT))
      picture.insert(picture.size(), $urandom);
  endtask

  task automatic send_picture(int unsigned first, int unsigned stop);
    for (int unsigned i = first; i < stop; i++) send_pixel(picture[i]);
  endtask

  task automatic touch_pixels(int unsigned n);
    int unsigned idx;
    logic [PIX_W-1:0] flip;
    repeat (n) begin
      idx = $urandom_range(0, picture.size() - 1);
      flip = $urandom;
      picture[idx] ^= (flip == 0) ? 32'd1 : flip;
    end
  endtask

  // Two tiles, the second one pixel wide, walked through every decision.
  task automatic test_frame_decisions();
    set_size(65, 1);
    send_picture(0, picture.size());
    send_picture(0, picture.size());
    picture[64] ^= 32'h0000_0001;
    send_picture(0, picture.size());
    picture[0] ^= 32'h8000_0000;
    picture[64] ^= 32'h0001_0000;
    send_picture(0, picture.size());
    write_reg(REG_THRESHOLD, 0);
    picture[3] ^= 32'h0000_0100;
    send_picture(0, picture.size());
    write_reg(REG_THRESHOLD, 100);
    picture[1] ^= 32'h0F00_0000;
    picture[64] ^= 32'h0000_00F0;
    send_picture(0, picture.size());
    write_reg(REG_THRESHOLD, 127);
    picture[2] ^= 32'h0000_0002;
    picture[64] ^= 32'h0000_0004;
    send_picture(0, picture.size());
    write_reg(REG_THRESHOLD, 49);
    picture[64] ^= 32'h0400_0000;
    send_picture(0, picture.size());
    write_reg(REG_THRESHOLD, 50);
    picture[10] ^= 32'h0000_8000;
    send_picture(0, picture.size());
    write_reg(REG_THRESHOLD, 55);
  endtask

  // A zero size is taken as one pixel, so every item closes a frame and each
  // pixel bit is checked on its own.
  task automatic test_pixel_bits();
    set_size(0, 0);
    send_pixel('0);
    send_pixel('0);
    send_pixel('1);
    send_pixel('1);
    for (int b = 0; b < PIX_W; b++) begin
      send_pixel(PIX_W'(1) << b);
      send_pixel('0);
    end
  endtask

  // Oversized frames are clamped to the maximum; the tile total carried by
  // the first tiles of a frame already shows it, so only a part is sent.
  task automatic test_size_extremes();
    set_size(2047, 1);
    send_picture(0, 2 * TILE_SIZE);
    set_size(1024, 1);
    send_picture(0, TILE_SIZE);
    set_size(1, 2047);
    send_picture(0, TILE_SIZE);
  endtask

  task automatic test_midframe_writes();
    set_size(10, 3);
    send_picture(0, picture.size());
    touch_pixels(2);
    send_picture(0, 13);
    write_reg(REG_THRESHOLD, 100);
    send_picture(13, picture.size());
    write_reg(REG_THRESHOLD, 55);
    send_picture(0, 7);
    write_reg(REG_FRAME_WIDTH, 10);
    send_picture(0, picture.size());
    send_picture(0, 20);
    write_reg(REG_FRAME_HEIGHT, 3);
    send_picture(0, picture.size());
    send_picture(0, picture.size());
  endtask

  task automatic test_random_frames();
    int unsigned start_pixels, start_tiles, w, h, pick, cut;
    start_pixels = pixels_sent;
    start_tiles = tiles_seen;
    while (pixels_sent - start_pixels < RANDOM_PIXELS ||
           tiles_seen - start_tiles < RANDOM_TILES) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        w = $urandom_range(1, 20);
        h = $urandom_range(1, 6);
      end else if (pick < 8) begin
        w = $urandom_range(60, 72);
        h = $urandom_range(1, 2);
      end else begin
        w = $urandom_range(1, 2);
        h = $urandom_range(60, 70);
      end
      set_size(w, h);
      if ($urandom_range(0, 2) == 0) write_reg(REG_THRESHOLD, $urandom_range(0, 127));
      repeat ($urandom_range(2, 5)) begin
        steady = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 3))
          0: ;
          1: touch_pixels($urandom_range(1, 3));
          2: touch_pixels($urandom_range(1, picture.size()));
          default: foreach (picture[i]) picture[i] = $urandom;
        endcase
        if ($urandom_range(0, 7) == 0) begin
          // The stream holds mid-frame until all reports have drained.
          cut = $urandom_range(0, picture.size() - 1);
          send_picture(0, cut);
          wait_idle();
          send_picture(cut, picture.size());
        end else begin
          send_picture(0, picture.size());
        end
      end
      steady = 1'b0;
      // Now and then a frame is cut short by the next size write.
      if ($urandom_range(0, 9) == 0) send_picture(0, $urandom_range(0, picture.size() - 1));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_frame_decisions();
    test_pixel_bits();
    test_size_extremes();
    test_midframe_writes();
    test_random_frames();
    wait_idle();
    if (mismatches == 0 && expected_tiles.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
